FILE: sv/tlf_pkg.sv
`timescale 1ns / 1ps
package tlf_pkg;

	// register indexes on the configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

	// character codes
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NL        = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DOLLAR    = 8'h24;
	localparam logic [7:0] CH_QMARK     = 8'h3F;
	localparam logic [7:0] CH_I         = 8'h49;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CH_DEL       = 8'h7F;
	localparam logic [7:0] CH_PRINT_MIN = 8'h20;
	localparam logic [7:0] CTRL_OFFSET  = 8'h40;
	localparam logic [3:0] DIGIT_HI     = 4'h3;
	localparam logic [3:0] BCD_NINE     = 4'h9;

	// minimum width of the line number field
	localparam int NUM_FIELD_MIN = 6;

	typedef struct packed {
		logic number_nonblank;
		logic show_ends;
		logic number_all;
		logic squeeze_blank;
		logic show_tabs;
		logic show_nonprinting;
	} tlf_cfg_t;

	// one queued job: optional number field, then one or two bytes
	typedef struct packed {
		logic       num;
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
	} tlf_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tlf_qstat_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_NUM,
		PH_TAB,
		PH_B0,
		PH_B1
	} tlf_phase_t;

endpackage

FILE: sv/tlf_front.sv
`timescale 1ns / 1ps
module tlf_front #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tlf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic                             cfg_data,
	input  logic                             in_valid,
	input  logic [7:0]                       in_byte,
	output logic                             in_stall,
	input  tlf_pkg::tlf_qstat_t              q_stat,
	output logic                             q_push,
	output tlf_pkg::tlf_ctl_t                q_ctl,
	output logic [4*MAX_DIGITS-1:0]          q_bcd
);
	import tlf_pkg::*;

	localparam int BW = 4 * MAX_DIGITS;

	tlf_cfg_t        cfg_q;
	logic [BW-1:0]   line_number_q;
	logic            at_line_start_q;
	logic            prev_blank_q;

	logic            accept;
	logic            blank;
	logic            drop;
	logic            prev_blank_d;
	logic            numbered;
	logic [BW-1:0]   line_inc;
	logic            all_nines;
	logic            carry;
	logic [3:0]      dig;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data;
				CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data;
				CFG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data;
				CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data;
				CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data;
				CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;
	assign blank    = (in_byte == CH_NL);

	// line start decisions
	always_comb begin
		drop         = 1'b0;
		prev_blank_d = prev_blank_q;
		numbered     = 1'b0;
		if (at_line_start_q) begin
			if (cfg_q.squeeze_blank && blank && prev_blank_q)
				drop = 1'b1;
			prev_blank_d = cfg_q.squeeze_blank && blank;
			if (cfg_q.number_nonblank)
				numbered = !blank;
			else
				numbered = cfg_q.number_all;
		end
	end

	// byte classification
	always_comb begin
		q_ctl     = '0;
		q_ctl.num = numbered;
		q_ctl.b0  = in_byte;
		if (in_byte == CH_TAB && cfg_q.show_tabs) begin
			q_ctl.two = 1'b1;
			q_ctl.b0  = CH_CARET;
			q_ctl.b1  = CH_I;
		end else if (blank) begin
			q_ctl.two = cfg_q.show_ends;
			q_ctl.b0  = cfg_q.show_ends ? CH_DOLLAR : CH_NL;
			q_ctl.b1  = CH_NL;
		end else if (cfg_q.show_nonprinting && in_byte != CH_TAB &&
				(in_byte < CH_PRINT_MIN || in_byte[7])) begin
			q_ctl.two = 1'b1;
			q_ctl.b0  = CH_CARET;
			q_ctl.b1  = in_byte + CTRL_OFFSET;
		end else if (cfg_q.show_nonprinting && in_byte == CH_DEL) begin
			q_ctl.two = 1'b1;
			q_ctl.b0  = CH_CARET;
			q_ctl.b1  = CH_QMARK;
		end
	end

	assign q_push = accept && !drop;
	assign q_bcd  = line_number_q;

	// saturating BCD increment, ripple over the digits
	always_comb begin
		all_nines = 1'b1;
		carry     = 1'b1;
		line_inc  = line_number_q;
		for (int p = 0; p < MAX_DIGITS; p++) begin
			dig = line_number_q[4*p +: 4];
			if (dig != BCD_NINE)
				all_nines = 1'b0;
			if (carry) begin
				if (dig >= BCD_NINE) begin
					line_inc[4*p +: 4] = 4'h0;
				end else begin
					line_inc[4*p +: 4] = dig + 4'h1;
					carry = 1'b0;
				end
			end
		end
		if (all_nines)
			line_inc = line_number_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_number_q   <= BW'(1);
			at_line_start_q <= 1'b1;
			prev_blank_q    <= 1'b0;
		end else if (q_push) begin
			at_line_start_q <= blank;
			prev_blank_q    <= prev_blank_d;
			if (numbered)
				line_number_q <= line_inc;
		end
	end

endmodule

FILE: sv/tlf_fifo.sv
`timescale 1ns / 1ps
module tlf_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [DW-1:0]       din,
	input  logic                pop,
	output logic [DW-1:0]       dout,
	output tlf_pkg::tlf_qstat_t stat
);
	import tlf_pkg::*;

	// DEPTH is a power of two; pointers wrap naturally
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign dout       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

FILE: sv/tlf_back.sv
`timescale 1ns / 1ps
module tlf_back #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  tlf_pkg::tlf_ctl_t       q_ctl,
	input  logic [4*MAX_DIGITS-1:0] q_bcd,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              out_byte,
	output logic                    last
);
	import tlf_pkg::*;

	localparam int PW = $clog2(MAX_DIGITS + 1);
	localparam int IW = $clog2(MAX_DIGITS);

	tlf_phase_t    phase_q, phase_d, cur_phase;
	logic [PW-1:0] p_q, p_d, cur_p;
	logic [PW-1:0] sig;
	logic [PW-1:0] field_w;
	logic [3:0]    dig;
	logic          load;
	logic [7:0]    byte_d;
	logic          last_d;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          last_q;

	// significant digits and field width of the head entry
	always_comb begin
		sig = PW'(1);
		for (int p = 0; p < MAX_DIGITS; p++)
			if (q_bcd[4*p +: 4] != 4'h0)
				sig = PW'(p + 1);
		field_w = (sig > PW'(NUM_FIELD_MIN)) ? sig : PW'(NUM_FIELD_MIN);
	end

	assign load = !q_empty && (!out_valid_q || !out_stall);

	always_comb begin
		if (phase_q == PH_START) begin
			cur_phase = q_ctl.num ? PH_NUM : PH_B0;
			cur_p     = field_w - PW'(1);
		end else begin
			cur_phase = phase_q;
			cur_p     = p_q;
		end
		dig     = q_bcd[4*cur_p[IW-1:0] +: 4];
		phase_d = phase_q;
		p_d     = p_q;
		byte_d  = CH_SPACE;
		last_d  = 1'b0;
		q_pop   = 1'b0;
		if (load) begin
			case (cur_phase)
				PH_NUM: begin
					byte_d  = (cur_p < sig) ? {DIGIT_HI, dig} : CH_SPACE;
					phase_d = (cur_p == '0) ? PH_TAB : PH_NUM;
					p_d     = cur_p - PW'(1);
				end
				PH_TAB: begin
					byte_d  = CH_TAB;
					phase_d = PH_B0;
				end
				PH_B0: begin
					byte_d = q_ctl.b0;
					if (q_ctl.two) begin
						phase_d = PH_B1;
					end else begin
						last_d  = 1'b1;
						q_pop   = 1'b1;
						phase_d = PH_START;
					end
				end
				PH_B1: begin
					byte_d  = q_ctl.b1;
					last_d  = 1'b1;
					q_pop   = 1'b1;
					phase_d = PH_START;
				end
				default: phase_d = PH_START;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			p_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			p_q     <= p_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_d;
			last_q     <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

FILE: sv/text_line_formatter_top.sv
`timescale 1ns / 1ps
// Text line formatter: byte stream filter with line numbering, blank line
// squeezing, end marks and caret display of tabs and control bytes.
// Input channel: in_valid / in_stall carrying in_byte, one raw byte a beat.
// Output channel: out_valid / out_stall carrying out_byte and last; last
// marks the final output beat produced by one input byte.
// Config: cfg_we / cfg_index / cfg_data, one bit per register. The user
// must write them only while the block is idle; the block does not
// enforce this. Unknown indexes are ignored.
// Throughput: one output beat per cycle while a job waits and out_stall
// is low, set by the back end output register. A byte of n beats (up to
// max(MAX_DIGITS, NUM_FIELD_MIN) + 3) holds the back end until all n are
// out; the front keeps taking bytes until the queue of QUEUE_DEPTH jobs
// fills, then raises in_stall. A squeezed blank line produces no beats.
// Reset: config cleared, line number one, at line start, queue emptied,
// out_valid low.
// Receiver stall: the output beat holds; the queue then fills and in_stall
// rises. Each side otherwise runs on its own.
module text_line_formatter_top #(
	parameter int MAX_DIGITS  = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tlf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          last
);
	import tlf_pkg::*;

	localparam int BW = 4 * MAX_DIGITS;
	localparam int DW = $bits(tlf_ctl_t) + BW;

	tlf_qstat_t      q_stat;
	logic            q_push;
	logic            q_pop;
	tlf_ctl_t        push_ctl;
	logic [BW-1:0]   push_bcd;
	tlf_ctl_t        head_ctl;
	logic [BW-1:0]   head_bcd;
	logic [DW-1:0]   head_data;

	// front: config, line state, classification, line number
	tlf_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_byte   (in_byte),
		.in_stall  (in_stall),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_ctl     (push_ctl),
		.q_bcd     (push_bcd)
	);

	// job queue between front and back
	tlf_fifo #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({push_ctl, push_bcd}),
		.pop    (q_pop),
		.dout   (head_data),
		.stat   (q_stat)
	);

	assign head_ctl = head_data[DW-1:BW];
	assign head_bcd = head_data[BW-1:0];

	// back: expands one job into output beats
	tlf_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_stat.empty),
		.q_ctl     (head_ctl),
		.q_bcd     (head_bcd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

`ifndef SYNTHESIS
	// never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into full queue");

	// an output beat only ever appears with a job at the queue head
	a_beat_from_job: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!q_stat.empty))
		else $error("output beat without a queued job");

	// a waiting job with a free output register always produces a beat
	a_back_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_stat.empty && (!out_valid || !out_stall)) |=> out_valid)
		else $error("back end stalled with work pending");
`endif

endmodule
